### rtl/core/obrb_pkg.sv
`timescale 1ns / 1ps

package obrb_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;
  localparam int REQ_W  = 2;
  localparam int BSZ_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // register index (byte address bit 2 selects the word)
  localparam logic REG_BUFFER_SIZE = 1'b0;

  localparam logic [BSZ_W-1:0] BSZ_RESET = BSZ_W'(DEPTH);

  // shared controls broadcast along the cell row
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic              tok_load;
    logic [IDX_W-1:0]  tok_idx;
    logic              tok_run;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

### rtl/core/obrb_cell.sv
`timescale 1ns / 1ps

module obrb_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  obrb_pkg::cell_ctrl_t        ctrl,
  input  logic                        wr_sel,
  input  logic                        tok_sel,
  input  logic                        tok_in,
  output logic [obrb_pkg::DATA_W-1:0] byte_o,
  output logic                        tok_o,
  output logic                        hit_o
);

  logic [obrb_pkg::DATA_W-1:0] byte_r;
  logic                        tok_r;

  // stored byte, no reset
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && wr_sel) begin
      byte_r <= ctrl.wr_data;
    end
  end

  // search token, handed on to the next cell each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctrl.tok_load) begin
      tok_r <= tok_sel;
    end else if (ctrl.tok_run) begin
      tok_r <= tok_in;
    end
  end

  assign byte_o = byte_r;
  assign tok_o  = tok_r;
  assign hit_o  = tok_r && (byte_r == ctrl.key);

endmodule

### rtl/core/obrb_ctrl.sv
`timescale 1ns / 1ps

module obrb_ctrl (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                start,
  output logic                                                busy,
  input  logic [obrb_pkg::REQ_W-1:0]                          req_type,
  input  logic [obrb_pkg::DATA_W-1:0]                         data_in,
  input  logic [obrb_pkg::CNT_W-1:0]                          cap,
  input  logic [obrb_pkg::DEPTH-1:0][obrb_pkg::DATA_W-1:0]    cell_byte,
  input  logic                                                hit_any,
  output obrb_pkg::cell_ctrl_t                                ctrl,
  output logic                                                out_valid,
  output logic [obrb_pkg::DATA_W-1:0]                         out_data_out,
  output logic                                                out_ok,
  output logic                                                out_overwrote,
  output logic                                                out_is_empty,
  output logic                                                out_is_full,
  output logic [obrb_pkg::CNT_W-1:0]                          out_fill_count
);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t                      state_r,  state_nxt;
  logic [obrb_pkg::IDX_W-1:0]  w_r,      w_nxt;
  logic [obrb_pkg::IDX_W-1:0]  r_r,      r_nxt;
  logic [obrb_pkg::CNT_W-1:0]  count_r,  count_nxt;
  logic [obrb_pkg::CNT_W-1:0]  steps_r,  steps_nxt;
  logic [obrb_pkg::DATA_W-1:0] key_r,    key_nxt;
  logic                        ov_r,     ov_nxt;
  logic [obrb_pkg::DATA_W-1:0] od_r,     od_nxt;
  logic                        ok_r,     ok_nxt;
  logic                        ovw_r,    ovw_nxt;
  logic                        emp_r,    emp_nxt;
  logic                        full_r,   full_nxt;
  logic [obrb_pkg::CNT_W-1:0]  fill_r,   fill_nxt;

  logic                        accept;
  logic                        is_full;
  logic [obrb_pkg::IDX_W-1:0]  adv_w;
  logic [obrb_pkg::IDX_W-1:0]  adv_r;

  assign busy    = (state_r == ST_SEARCH);
  assign accept  = start && !busy;
  assign is_full = (count_r >= cap);

  // index advance with wrap at the capacity in use
  always_comb begin
    adv_w = ((obrb_pkg::CNT_W'(w_r) + 1'b1) >= cap) ? '0 : w_r + 1'b1;
    adv_r = ((obrb_pkg::CNT_W'(r_r) + 1'b1) >= cap) ? '0 : r_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    r_nxt     = r_r;
    count_nxt = count_r;
    steps_nxt = steps_r;
    key_nxt   = key_r;
    ov_nxt    = 1'b0;
    od_nxt    = '0;
    ok_nxt    = 1'b0;
    ovw_nxt   = 1'b0;

    ctrl.wr_en    = 1'b0;
    ctrl.wr_idx   = w_r;
    ctrl.wr_data  = data_in;
    ctrl.tok_load = 1'b0;
    ctrl.tok_idx  = r_r;
    ctrl.tok_run  = 1'b0;
    ctrl.key      = key_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            obrb_pkg::REQ_PUT: begin
              ctrl.wr_en = 1'b1;
              if (is_full) begin
                r_nxt   = adv_r;
                ovw_nxt = 1'b1;
              end else begin
                count_nxt = count_r + 1'b1;
              end
              w_nxt  = adv_w;
              ok_nxt = 1'b1;
              ov_nxt = 1'b1;
            end
            obrb_pkg::REQ_GET: begin
              if (count_r != '0) begin
                od_nxt    = cell_byte[r_r];
                count_nxt = count_r - 1'b1;
                r_nxt     = adv_r;
                ok_nxt    = 1'b1;
              end
              ov_nxt = 1'b1;
            end
            obrb_pkg::REQ_SEARCH: begin
              key_nxt = data_in;
              if (count_r != '0) begin
                ctrl.tok_load = 1'b1;
                steps_nxt     = count_r;
                state_nxt     = ST_SEARCH;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        ctrl.tok_run = 1'b1;
        if (hit_any) begin
          ok_nxt    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (steps_r == obrb_pkg::CNT_W'(1)) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          steps_nxt = steps_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    emp_nxt  = (count_nxt == '0);
    full_nxt = (count_nxt >= cap);
    fill_nxt = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      w_r     <= '0;
      r_r     <= '0;
      count_r <= '0;
      steps_r <= '0;
      key_r   <= '0;
      ov_r    <= 1'b0;
      od_r    <= '0;
      ok_r    <= 1'b0;
      ovw_r   <= 1'b0;
      emp_r   <= 1'b1;
      full_r  <= 1'b0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      r_r     <= r_nxt;
      count_r <= count_nxt;
      steps_r <= steps_nxt;
      key_r   <= key_nxt;
      ov_r    <= ov_nxt;
      od_r    <= od_nxt;
      ok_r    <= ok_nxt;
      ovw_r   <= ovw_nxt;
      emp_r   <= emp_nxt;
      full_r  <= full_nxt;
      fill_r  <= fill_nxt;
    end
  end

  assign out_valid      = ov_r;
  assign out_data_out   = od_r;
  assign out_ok         = ok_r;
  assign out_overwrote  = ovw_r;
  assign out_is_empty   = emp_r;
  assign out_is_full    = full_r;
  assign out_fill_count = fill_r;

`ifndef SYNTHESIS
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req_type != obrb_pkg::REQ_SEARCH || count_r == '0)) |=> ov_r)
    else $error("single-cycle request gave no result");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req_type == obrb_pkg::REQ_SEARCH && count_r != '0) |=> (!ov_r && busy))
    else $error("search walk did not start");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= obrb_pkg::CNT_W'(obrb_pkg::DEPTH))
    else $error("fill count above depth");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (steps_r != '0 && steps_r <= count_r))
    else $error("search step count out of range");
`endif

endmodule

### rtl/core/overwriting_byte_ring_buffer_unit.sv
`timescale 1ns / 1ps

// overwriting byte ring buffer: a byte fifo that drops its oldest byte when full
// - command channel: start, in_req_type (put, get, search), in_data_in; a word is
//   taken at a clock edge with start high and busy low
// - result channel: out_valid strobes one cycle per request with out_data_out,
//   out_ok, out_overwrote, out_is_empty, out_is_full and out_fill_count
// - apb port: one register, buffer_size, at byte address 0 (capacity in use,
//   0 acts as 1, above 16 acts as 16); write it only while the unit is idle
// - put, get and the unused code need no walk: the result strobes in the
//   cycle after start and busy stays low, so one word per cycle is taken
// - a search walks a token along the row of byte cells from the read index,
//   one cell per cycle, following the same wrap as the indices; it visits as
//   many cells as bytes are held (1 to 16) or stops at the first match, with
//   busy high for that walk; an empty buffer answers without a walk
// - the result always leaves the cycle after the request finishes; there is no
//   back-pressure on the result side
// - reset (synchronous, active low) empties the buffer, clears both indices and
//   sets buffer_size to 16; stored bytes are not cleared

module overwriting_byte_ring_buffer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [obrb_pkg::REQ_W-1:0]           in_req_type,
  input  logic [obrb_pkg::DATA_W-1:0]          in_data_in,
  // result channel
  output logic                                 out_valid,
  output logic [obrb_pkg::DATA_W-1:0]          out_data_out,
  output logic                                 out_ok,
  output logic                                 out_overwrote,
  output logic                                 out_is_empty,
  output logic                                 out_is_full,
  output logic [obrb_pkg::CNT_W-1:0]           out_fill_count,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [obrb_pkg::APB_AW-1:0]          paddr,
  input  logic [obrb_pkg::APB_DW-1:0]          pwdata,
  output logic [obrb_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  logic [obrb_pkg::BSZ_W-1:0]                       bsz_r;
  logic [obrb_pkg::CNT_W-1:0]                       cap;
  logic                                             cfg_wr;

  obrb_pkg::cell_ctrl_t                             ctrl;
  logic [obrb_pkg::DEPTH-1:0][obrb_pkg::DATA_W-1:0] cell_byte;
  logic [obrb_pkg::DEPTH-1:0]                       tok_o;
  logic [obrb_pkg::DEPTH-1:0]                       tok_in;
  logic [obrb_pkg::DEPTH-1:0]                       hit;
  logic [obrb_pkg::DEPTH-1:0]                       wrap;
  logic                                             hit_any;

  // config register, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsz_r <= obrb_pkg::BSZ_RESET;
    end else if (cfg_wr && paddr[2] == obrb_pkg::REG_BUFFER_SIZE) begin
      bsz_r <= pwdata[obrb_pkg::BSZ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == obrb_pkg::REG_BUFFER_SIZE) ?
                  obrb_pkg::APB_DW'(bsz_r) : '0;

  // capacity in use, clamped to 1..DEPTH
  always_comb begin
    if (bsz_r == '0) begin
      cap = obrb_pkg::CNT_W'(1);
    end else if (obrb_pkg::CNT_W'(bsz_r) > obrb_pkg::CNT_W'(obrb_pkg::DEPTH)) begin
      cap = obrb_pkg::CNT_W'(obrb_pkg::DEPTH);
    end else begin
      cap = obrb_pkg::CNT_W'(bsz_r);
    end
  end

  // token links: a cell at or past the last slot in use hands to cell 0,
  // every other cell to its right-hand neighbor
  always_comb begin
    for (int i = 0; i < obrb_pkg::DEPTH; i++) begin
      wrap[i] = (obrb_pkg::CNT_W'(i + 1) >= cap);
    end
    tok_in[0] = |(tok_o & wrap);
    for (int j = 1; j < obrb_pkg::DEPTH; j++) begin
      tok_in[j] = tok_o[j-1] && !wrap[j-1];
    end
  end

  assign hit_any = |hit;

  obrb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (in_req_type),
    .data_in        (in_data_in),
    .cap            (cap),
    .cell_byte      (cell_byte),
    .hit_any        (hit_any),
    .ctrl           (ctrl),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_ok         (out_ok),
    .out_overwrote  (out_overwrote),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_fill_count (out_fill_count)
  );

  // row of byte cells, one per store slot
  for (genvar g = 0; g < obrb_pkg::DEPTH; g++) begin : g_cell
    obrb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .wr_sel  (ctrl.wr_idx == obrb_pkg::IDX_W'(g)),
      .tok_sel (ctrl.tok_idx == obrb_pkg::IDX_W'(g)),
      .tok_in  (tok_in[g]),
      .byte_o  (cell_byte[g]),
      .tok_o   (tok_o[g]),
      .hit_o   (hit[g])
    );
  end

`ifndef SYNTHESIS
  a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $onehot(tok_o))
    else $error("search token lost or duplicated");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap != '0 && cap <= obrb_pkg::CNT_W'(obrb_pkg::DEPTH)))
    else $error("capacity out of range");

  a_wrap_last: assert property (@(posedge clk) disable iff (!rst_n)
    wrap[obrb_pkg::DEPTH-1])
    else $error("last cell does not wrap");
`endif

endmodule

### tb/tb_overwriting_byte_ring_buffer_unit.sv
`timescale 1ns / 1ps

module tb_overwriting_byte_ring_buffer_unit;

  // code 3 of the request field selects nothing in the unit
  localparam logic [obrb_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  // buffer_size is register 0, word-aligned at byte address 0
  localparam logic [obrb_pkg::APB_AW-1:0] ADDR_BUFFER_SIZE = {obrb_pkg::REG_BUFFER_SIZE, 2'b00};
  // every word yields a result, so a short settle after the last one is plenty
  localparam int IDLE_SETTLE = 4;
  localparam int DRAIN_CYCLES = 20;
  // longest sender gap; a search walk can hold the sender longer
  localparam int MAX_GAP = 40;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int NUM_PHASES = 9;
  localparam int WORDS_PER_PHASE = 215;

  typedef struct packed {
    logic [obrb_pkg::DATA_W-1:0] data_out;
    logic                        ok;
    logic                        overwrote;
    logic                        is_empty;
    logic                        is_full;
    logic [obrb_pkg::CNT_W-1:0]  fill_count;
  } fifo_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed script; a config line carries buffer_size in data
  typedef struct {
    row_kind_t                   kind;
    logic [obrb_pkg::REQ_W-1:0]  req;
    logic [obrb_pkg::DATA_W-1:0] data;
    logic                        typed;
    fifo_result_t                res;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic [obrb_pkg::REQ_W-1:0]  in_req_type = '0;
  logic [obrb_pkg::DATA_W-1:0] in_data_in = '0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [obrb_pkg::APB_AW-1:0] paddr = '0;
  logic [obrb_pkg::APB_DW-1:0] pwdata = '0;

  logic                        busy;
  logic                        out_valid;
  logic [obrb_pkg::DATA_W-1:0] out_data_out;
  logic                        out_ok;
  logic                        out_overwrote;
  logic                        out_is_empty;
  logic                        out_is_full;
  logic [obrb_pkg::CNT_W-1:0]  out_fill_count;
  logic [obrb_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  overwriting_byte_ring_buffer_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_ok         (out_ok),
    .out_overwrote  (out_overwrote),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_fill_count (out_fill_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the buffer, kept in step with every accepted word
  logic [obrb_pkg::DATA_W-1:0] shadow_bytes [obrb_pkg::DEPTH];
  logic [obrb_pkg::DEPTH-1:0]  shadow_written = '0;   // entries that ever got a put
  int                          shadow_wr = 0;
  int                          shadow_rd = 0;
  int                          shadow_count = 0;
  logic [obrb_pkg::BSZ_W-1:0]  shadow_bsz = obrb_pkg::BSZ_RESET;

  // results still owed by the unit, oldest first
  fifo_result_t pending_results [$];

  int mismatches = 0;
  int stall_cycles = 0;
  int n_put = 0, n_get = 0, n_search = 0, n_unused = 0;
  int n_overwrite = 0, n_hit = 0, n_cfg = 0;

  // capacity in use: 0 behaves as 1, anything above DEPTH as DEPTH
  function automatic int fifo_capacity();
    if (shadow_bsz == 0) return 1;
    if (shadow_bsz > obrb_pkg::DEPTH) return obrb_pkg::DEPTH;
    return int'(shadow_bsz);
  endfunction

  // index step, wrapping at the capacity in use
  function automatic int wrap_next(int idx);
    int nxt;
    nxt = idx + 1;
    if (nxt >= fifo_capacity()) nxt = 0;
    return nxt;
  endfunction

  // applies one request to the shadow buffer and returns what the unit should say
  function automatic fifo_result_t predict_request(logic [obrb_pkg::REQ_W-1:0] req,
                                                   logic [obrb_pkg::DATA_W-1:0] data);
    fifo_result_t r;
    int cap;
    int pos;
    r = '0;
    cap = fifo_capacity();
    case (req)
      obrb_pkg::REQ_PUT: begin
        shadow_bytes[shadow_wr % obrb_pkg::DEPTH] = data;
        shadow_written[shadow_wr % obrb_pkg::DEPTH] = 1'b1;
        if (shadow_count >= cap) begin
          // full: the oldest byte goes
          shadow_rd = wrap_next(shadow_rd);
          r.overwrote = 1'b1;
        end else begin
          shadow_count++;
        end
        shadow_wr = wrap_next(shadow_wr);
        r.ok = 1'b1;
      end
      obrb_pkg::REQ_GET: begin
        if (shadow_count != 0) begin
          r.data_out = shadow_bytes[shadow_rd % obrb_pkg::DEPTH];
          shadow_count--;
          shadow_rd = wrap_next(shadow_rd);
          r.ok = 1'b1;
        end
      end
      obrb_pkg::REQ_SEARCH: begin
        pos = shadow_rd;
        for (int k = 0; k < shadow_count && !r.ok; k++) begin
          if (shadow_bytes[pos % obrb_pkg::DEPTH] == data) r.ok = 1'b1;
          pos = wrap_next(pos);
        end
      end
      default: ;
    endcase
    r.is_empty = (shadow_count == 0);
    r.is_full = (shadow_count >= cap);
    r.fill_count = obrb_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // true when a get or search would touch an entry that never got a put;
  // only reachable after the capacity was raised with bytes held
  function automatic logic reads_unwritten(logic [obrb_pkg::REQ_W-1:0] req);
    int pos;
    logic miss;
    pos = shadow_rd;
    miss = 1'b0;
    if (req == obrb_pkg::REQ_GET && shadow_count != 0) begin
      miss = !shadow_written[pos % obrb_pkg::DEPTH];
    end
    if (req == obrb_pkg::REQ_SEARCH) begin
      for (int k = 0; k < shadow_count; k++) begin
        if (!shadow_written[pos % obrb_pkg::DEPTH]) miss = 1'b1;
        pos = wrap_next(pos);
      end
    end
    return miss;
  endfunction

  function automatic fifo_result_t outcome(logic [obrb_pkg::DATA_W-1:0] d, int ok, int ovw,
                                           int empty, int full, int cnt);
    fifo_result_t r;
    r.data_out = d;
    r.ok = (ok != 0);
    r.overwrote = (ovw != 0);
    r.is_empty = (empty != 0);
    r.is_full = (full != 0);
    r.fill_count = obrb_pkg::CNT_W'(cnt);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // presents one word and holds it until the unit takes it (busy low at the edge)
  task automatic issue_word(input logic [obrb_pkg::REQ_W-1:0] req,
                            input logic [obrb_pkg::DATA_W-1:0] data,
                            input logic typed, input fifo_result_t typed_res);
    fifo_result_t predicted;
    start <= 1'b1;
    in_req_type <= req;
    in_data_in <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_request(req, data);
    pending_results.push_back(typed ? typed_res : predicted);
    case (req)
      obrb_pkg::REQ_PUT:    begin n_put++; if (predicted.overwrote) n_overwrite++; end
      obrb_pkg::REQ_GET:    n_get++;
      obrb_pkg::REQ_SEARCH: begin n_search++; if (predicted.ok) n_hit++; end
      default:              n_unused++;
    endcase
  endtask

  // every word answers, so an empty queue means the unit is done
  task automatic wait_until_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // apb write of buffer_size followed by a read back of the same register
  task automatic write_buffer_size(input logic [obrb_pkg::BSZ_W-1:0] value);
    logic [obrb_pkg::APB_DW-1:0] word;
    word = $urandom();
    word[obrb_pkg::BSZ_W-1:0] = value;
    wait_until_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BUFFER_SIZE;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_bsz = value;
    n_cfg++;
    // read phase: psel stays high, new setup cycle
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // only the implemented bits are compared
    check_field("buffer_size read back", 32'(value),
                32'(prdata[obrb_pkg::BSZ_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: no back-pressure, so every strobe is checked on the spot
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got data_out %0h ok %0b fill %0d",
                 $time, out_data_out, out_ok, out_fill_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", 32'(want.data_out), 32'(out_data_out));
        check_field("ok", 32'(want.ok), 32'(out_ok));
        check_field("overwrote", 32'(want.overwrote), 32'(out_overwrote));
        check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
        check_field("is_full", 32'(want.is_full), 32'(out_is_full));
        check_field("fill_count", 32'(want.fill_count), 32'(out_fill_count));
      end
    end
  end

  // watchdog: cycles with neither a word taken nor a result seen
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];
    int phase_bsz [NUM_PHASES];
    int phase_idle [NUM_PHASES];
    int idle_pct;
    int put_pct;
    int burst_left;
    int gap;
    int k;
    int pos;
    logic [obrb_pkg::REQ_W-1:0] req;
    logic [obrb_pkg::DATA_W-1:0] data;

    // directed script: empty buffer first, then full and overwrite at capacity 2,
    // a shrink to 0 (acts as 1) with a byte held, and 31 (acts as 16)
    script = '{
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b1, outcome(8'h00, 0, 0, 1, 0, 0)},
      '{ROW_REQ, obrb_pkg::REQ_SEARCH, 8'h00, 1'b1, outcome(8'h00, 0, 0, 1, 0, 0)},
      '{ROW_REQ, REQ_UNUSED,           8'hFF, 1'b1, outcome(8'h00, 0, 0, 1, 0, 0)},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'h00, 1'b1, outcome(8'h00, 1, 0, 0, 0, 1)},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'hFF, 1'b1, outcome(8'h00, 1, 0, 0, 0, 2)},
      '{ROW_REQ, obrb_pkg::REQ_SEARCH, 8'hFF, 1'b1, outcome(8'h00, 1, 0, 0, 0, 2)},
      '{ROW_REQ, obrb_pkg::REQ_SEARCH, 8'h5A, 1'b1, outcome(8'h00, 0, 0, 0, 0, 2)},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b1, outcome(8'h00, 1, 0, 0, 0, 1)},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b1, outcome(8'hFF, 1, 0, 1, 0, 0)},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b1, outcome(8'h00, 0, 0, 1, 0, 0)},
      '{ROW_CFG, obrb_pkg::REQ_PUT,    8'd2,  1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'hA5, 1'b1, outcome(8'h00, 1, 0, 0, 0, 1)},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'h3C, 1'b1, outcome(8'h00, 1, 0, 0, 1, 2)},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'h81, 1'b1, outcome(8'h00, 1, 1, 0, 1, 2)},
      '{ROW_REQ, obrb_pkg::REQ_SEARCH, 8'hA5, 1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b0, '0},
      '{ROW_CFG, obrb_pkg::REQ_PUT,    8'd0,  1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'h7E, 1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_GET,    8'h00, 1'b1, outcome(8'h00, 0, 0, 1, 0, 0)},
      '{ROW_CFG, obrb_pkg::REQ_PUT,    8'd31, 1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_PUT,    8'hC3, 1'b0, '0},
      '{ROW_REQ, obrb_pkg::REQ_SEARCH, 8'hC3, 1'b0, '0},
      '{ROW_REQ, REQ_UNUSED,           8'h00, 1'b0, '0}
    };

    // capacity per random phase; slot 7 gets a random mid value below
    phase_bsz = '{16, 1, 31, 5, 0, 17, 2, 8, 16};
    // sender idle percentage per phase; the result side cannot stall
    phase_idle = '{0, 81, 0, 14, 0, 81, 14, 0, 81};
    phase_bsz[7] = $urandom_range(3, 15);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        write_buffer_size(obrb_pkg::BSZ_W'(script[i].data));
      end else begin
        issue_word(script[i].req, script[i].data, script[i].typed, script[i].res);
      end
    end

    // random phases: bursts lean toward puts or toward gets so both full and
    // empty get visited, searches often look for a byte that is held
    burst_left = 0;
    put_pct = 50;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_buffer_size(obrb_pkg::BSZ_W'(phase_bsz[p]));
      idle_pct = phase_idle[p];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          put_pct = $urandom_range(15, 85);
          burst_left = $urandom_range(8, 40);
        end
        burst_left--;

        if ($urandom_range(0, 99) < 3) req = REQ_UNUSED;
        else if ($urandom_range(0, 99) < put_pct) req = obrb_pkg::REQ_PUT;
        else if ($urandom_range(0, 9) < 6) req = obrb_pkg::REQ_GET;
        else req = obrb_pkg::REQ_SEARCH;
        // never read a store entry that has not been written
        if (reads_unwritten(req)) req = obrb_pkg::REQ_PUT;

        data = obrb_pkg::DATA_W'($urandom_range(0, 255));
        if (req == obrb_pkg::REQ_PUT) begin
          k = $urandom_range(0, 9);
          if (k == 0) data = 8'h00;
          else if (k == 1) data = 8'hFF;
        end else if (req == obrb_pkg::REQ_SEARCH && shadow_count != 0 &&
                     $urandom_range(0, 1) == 1) begin
          // look for a byte that sits somewhere in the valid window
          k = $urandom_range(0, shadow_count - 1);
          pos = shadow_rd;
          repeat (k) pos = wrap_next(pos);
          data = shadow_bytes[pos % obrb_pkg::DEPTH];
        end

        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        issue_word(req, data, 1'b0, '0);
      end
    end

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d puts (%0d dropped the oldest byte), %0d gets,",
             n_put + n_get + n_search + n_unused, n_put, n_overwrite, n_get);
    $display("%0d searches (%0d hits), %0d unused codes, %0d buffer_size writes",
             n_search, n_hit, n_unused, n_cfg);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/obrb_pkg.sv
rtl/core/obrb_cell.sv
rtl/core/obrb_ctrl.sv
rtl/core/overwriting_byte_ring_buffer_unit.sv
tb/tb_overwriting_byte_ring_buffer_unit.sv
